FILE: rtl/skewed_ar_envelope_generator_macros.svh
// Assertion macros for the envelope generator.
// Both macros assume a clock named clk and an active-low reset named arst_n.
`ifndef SKEWED_AR_ENVELOPE_GENERATOR_MACROS_SVH
`define SKEWED_AR_ENVELOPE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SAEG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SAEG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAEG_ASSERT_NOW(label, ante, cons, msg)
`define SAEG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/saeg_pkg.sv
`timescale 1ns / 1ps

package saeg_pkg;

	localparam int LEVEL_FRACTION_BITS_DEF = 16;

	localparam int RATE_W  = 27;
	localparam int SHAPE_W = 13;
	localparam int SKEW_W  = 30;  // floor(rate * shape / 2048)
	localparam int DAC_W   = 12;
	localparam int LED_W   = 7;
	localparam int CODE_W  = 2;

	localparam logic [DAC_W-1:0] DAC_FULL = 12'd3968;

	localparam logic [1:0] MODE_CYCLE = 2'd0;
	localparam logic [1:0] MODE_GATE  = 2'd1;

	typedef enum logic [1:0] {
		REG_RUN_MODE     = 2'd0,
		REG_ATTACK_RATE  = 2'd1,
		REG_RELEASE_RATE = 2'd2,
		REG_SHAPE_SKEW   = 2'd3
	} reg_idx_t;

	localparam logic [CODE_W-1:0] CODE_ATTACK  = 2'd0;
	localparam logic [CODE_W-1:0] CODE_SUSTAIN = 2'd1;
	localparam logic [CODE_W-1:0] CODE_RELEASE = 2'd2;
	localparam logic [CODE_W-1:0] CODE_END     = 2'd3;

	typedef enum logic [3:0] {
		STG_ATTACK  = 4'b0001,
		STG_SUSTAIN = 4'b0010,
		STG_RELEASE = 4'b0100,
		STG_END     = 4'b1000
	} stage_t;

	typedef struct packed {
		logic [1:0]               run_mode;
		logic [RATE_W-1:0]        attack_rate;
		logic [RATE_W-1:0]        release_rate;
		logic                     shape_pos;
		logic signed [SKEW_W-1:0] rise_scale;
		logic signed [SKEW_W-1:0] fall_scale;
	} cfg_t;

	function automatic logic [CODE_W-1:0] stage_code(input stage_t s);
		logic [CODE_W-1:0] c;
		unique case (s)
			STG_ATTACK:  c = CODE_ATTACK;
			STG_SUSTAIN: c = CODE_SUSTAIN;
			STG_RELEASE: c = CODE_RELEASE;
			default:     c = CODE_END;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/saeg_cfg.sv
`timescale 1ns / 1ps

module saeg_cfg
	import saeg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  reg_idx_t          wr_index,
	input  logic [RATE_W-1:0] wr_data,
	output cfg_t              cfg
);

	logic [1:0]                run_mode_q;
	logic [RATE_W-1:0]         attack_rate_q;
	logic [RATE_W-1:0]         release_rate_q;
	logic signed [SHAPE_W-1:0] shape_skew_q;
	logic signed [SKEW_W-1:0]  rise_scale_q;
	logic signed [SKEW_W-1:0]  fall_scale_q;

	logic signed [RATE_W+SHAPE_W:0] a_prod;
	logic signed [RATE_W+SHAPE_W:0] r_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q     <= MODE_GATE;
			attack_rate_q  <= RATE_W'(1);
			release_rate_q <= RATE_W'(1);
			shape_skew_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RUN_MODE:     run_mode_q     <= wr_data[1:0];
				REG_ATTACK_RATE:  attack_rate_q  <= wr_data;
				REG_RELEASE_RATE: release_rate_q <= wr_data;
				default:          shape_skew_q   <= $signed(wr_data[SHAPE_W-1:0]);
			endcase
		end
	end

	// skew scale per rate; floor of /2048 is the arithmetic drop of 11 bits
	assign a_prod = $signed({1'b0, attack_rate_q}) * shape_skew_q;
	assign r_prod = $signed({1'b0, release_rate_q}) * shape_skew_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_scale_q <= '0;
			fall_scale_q <= '0;
		end else begin
			rise_scale_q <= a_prod[RATE_W+SHAPE_W:11];
			fall_scale_q <= r_prod[RATE_W+SHAPE_W:11];
		end
	end

	assign cfg.run_mode     = run_mode_q;
	assign cfg.attack_rate  = attack_rate_q;
	assign cfg.release_rate = release_rate_q;
	assign cfg.shape_pos    = (shape_skew_q > 0);
	assign cfg.rise_scale   = rise_scale_q;
	assign cfg.fall_scale   = fall_scale_q;

endmodule

FILE: rtl/saeg_core.sv
`timescale 1ns / 1ps

module saeg_core
	import saeg_pkg::*;
#(
	parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic              op,
	input  logic              gate_low,
	input  cfg_t              cfg,
	output logic [DAC_W-1:0]  dac_value,
	output logic [LED_W-1:0]  led_value,
	output logic [CODE_W-1:0] stage_now
);

	localparam int F  = LEVEL_FRACTION_BITS;
	localparam int LW = F + 12;          // level, unsigned
	localparam int PW = F + 12;          // phase, signed
	localparam int XW = F + 33;          // working width
	localparam int S  = F + 10;          // phase term shift
	localparam int QW = PW + SKEW_W;     // product width
	localparam int TW = QW - S;          // skew term width

	localparam logic signed [XW-1:0] MAXL = $signed(XW'(DAC_FULL) << F);
	localparam logic signed [XW-1:0] MIDL = MAXL >>> 1;

	logic [LW-1:0]        level_q;
	logic signed [PW-1:0] lin_q;
	stage_t               stage_q;

	logic signed [SKEW_W-1:0] skew_sel;
	logic signed [QW-1:0]     prod;
	logic signed [XW-1:0]     term, lin_x, lev_x, ar_x, rr_x;
	logic signed [XW-1:0]     step_a, step_r, lev_up, lev_dn, lin_up, lin_dn;
	logic signed [XW-1:0]     comp_up, comp_cur;
	logic signed [XW-1:0]     lin_n, lev_n;
	stage_t                   stage_n;

	function automatic logic signed [XW-1:0] comp_phase(
		input logic signed [XW-1:0] lin,
		input logic signed [XW-1:0] lev,
		input logic                 pos
	);
		logic signed [XW-1:0] d, t, c, r;
		d = lin + MIDL - lev;
		t = (d <<< 2) + d;
		// halve toward zero
		c = t + {{(XW-1){1'b0}}, t[XW-1]};
		c = c >>> 1;
		r = pos ? lin + c : lin - c;
		if (r < -MIDL) begin
			r = -MIDL;
		end else if (r > MIDL) begin
			r = MIDL;
		end
		return r;
	endfunction

	function automatic logic signed [XW-1:0] clamp_level(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = v;
		if (v < 0) begin
			r = '0;
		end else if (v > MAXL) begin
			r = MAXL;
		end
		return r;
	endfunction

	assign skew_sel = (stage_q == STG_RELEASE) ? cfg.fall_scale : cfg.rise_scale;
	assign prod     = lin_q * skew_sel;
	assign term     = $signed({{(XW-TW){prod[QW-1]}}, prod[QW-1:S]});

	assign lin_x = $signed({{(XW-PW){lin_q[PW-1]}}, lin_q});
	assign lev_x = $signed({{(XW-LW){1'b0}}, level_q});
	assign ar_x  = $signed({{(XW-RATE_W){1'b0}}, cfg.attack_rate});
	assign rr_x  = $signed({{(XW-RATE_W){1'b0}}, cfg.release_rate});

	assign step_a = ar_x + term;
	assign step_r = rr_x - term;
	assign lev_up = (step_a > 0) ? lev_x + step_a : lev_x;
	assign lev_dn = (step_r > 0) ? lev_x - step_r : lev_x;
	assign lin_up = lin_x + ar_x;
	assign lin_dn = lin_x - rr_x;

	// compensation uses the level before saturation
	assign comp_up  = comp_phase(lin_up, lev_up, cfg.shape_pos);
	assign comp_cur = comp_phase(lin_x, lev_x, cfg.shape_pos);

	always_comb begin
		lin_n   = lin_x;
		lev_n   = lev_x;
		stage_n = stage_q;
		if (op) begin
			if (stage_q == STG_RELEASE) begin
				lin_n = comp_cur;
			end
			stage_n = STG_ATTACK;
		end else begin
			unique case (stage_q)
				STG_ATTACK: begin
					lev_n = clamp_level(lev_up);
					if (lin_up >= MIDL) begin
						lin_n   = MIDL;
						stage_n = STG_SUSTAIN;
					end else if (cfg.run_mode == MODE_GATE && gate_low) begin
						lin_n   = comp_up;
						stage_n = STG_RELEASE;
					end else begin
						lin_n = lin_up;
					end
				end
				STG_SUSTAIN: begin
					if (cfg.run_mode != MODE_GATE || gate_low) begin
						stage_n = STG_RELEASE;
					end
				end
				STG_RELEASE: begin
					if (lin_dn <= -MIDL) begin
						lin_n   = -MIDL;
						lev_n   = '0;
						stage_n = STG_END;
					end else begin
						lin_n = lin_dn;
						lev_n = clamp_level(lev_dn);
					end
				end
				default: begin
					if (cfg.run_mode == MODE_CYCLE) begin
						stage_n = STG_ATTACK;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			lin_q   <= PW'(-MIDL);
			stage_q <= STG_END;
		end else if (step_en) begin
			level_q <= lev_n[LW-1:0];
			lin_q   <= lin_n[PW-1:0];
			stage_q <= stage_n;
		end
	end

	assign dac_value = level_q[F+11:F];
	assign led_value = level_q[F+11:F+5];
	assign stage_now = stage_code(stage_q);

endmodule

FILE: rtl/skewed_ar_envelope_generator.sv
`timescale 1ns / 1ps
`include "skewed_ar_envelope_generator_macros.svh"

// Attack/sustain/release envelope with curve skew. Every accepted input
// transaction (a sample tick or a trigger, with the current gate level)
// yields exactly one result transaction carrying the 12-bit DAC code, the
// 7-bit LED code and the stage after the item. An item is taken into an
// input register, then the whole envelope update (one skew multiply, the
// level and phase adds, phase compensation and saturation) runs combinationally
// into the envelope state, which doubles as the result register. Sustained rate
// is one item per clock unless the result side stalls or a configuration write
// holds off the input; an accepted item waits in the input register until the
// result slot is free. The rate is set by the state feedback loop through the
// phase-by-skew multiplier. Configuration writes are always taken (cfg_ready is
// tied high); the input is held off in any cycle that carries one, and the skew
// scale factors are registered behind the written rate and shape registers.
module skewed_ar_envelope_generator
	import saeg_pkg::*;
#(
	parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [0] gate_low, rest zero
	input  logic [0:0]        s_axis_tuser,   // [0] op (0 tick, 1 trigger)

	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,   // [11:0] dac_value, [18:12] led_value,
	                                          // [20:19] stage_now, rest zero

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [RATE_W-1:0] cfg_data
);

	cfg_t cfg;

	// input register
	logic v_s1;
	logic op_s1;
	logic gate_low_s1;

	logic advance;
	logic m_valid_q;

	logic [DAC_W-1:0]  dac_value;
	logic [LED_W-1:0]  led_value;
	logic [CODE_W-1:0] stage_now;

	assign cfg_ready = 1'b1;

	saeg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (reg_idx_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the result slot is free when empty or being drained this cycle
	assign advance       = v_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = (!v_s1 || advance) && !cfg_valid;

	// an item that advances while the input is held off must still leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1       <= s_axis_tuser[0];
			gate_low_s1 <= s_axis_tdata[0];
		end
	end

	saeg_core #(
		.LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.op        (op_s1),
		.gate_low  (gate_low_s1),
		.cfg       (cfg),
		.dac_value (dac_value),
		.led_value (led_value),
		.stage_now (stage_now)
	);

	// envelope state only moves on advance, so the result stays put while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, stage_now, led_value, dac_value};

	`SAEG_ASSERT_NOW(a_dac_in_range, m_axis_tvalid, dac_value <= DAC_FULL, "dac above full scale")
	`SAEG_ASSERT_NOW(a_end_is_zero, stage_now == CODE_END, dac_value == '0, "end with nonzero level")
	`SAEG_ASSERT_NEXT(a_trig_attack, advance && op_s1, stage_now == CODE_ATTACK, "trigger missed attack")
	`SAEG_ASSERT_NOW(a_cfg_blocks_in, cfg_valid, !s_axis_tready, "input taken during config write")

endmodule

FILE: sim/envelope_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the envelope generator, keeps its own copy of the
// envelope and the register set, and compares every result transaction in order.
module envelope_checker
	import saeg_pkg::*;
#(
	parameter int LEVEL_FRACTION_BITS = LEVEL_FRACTION_BITS_DEF
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [0] gate_low
	input  logic [0:0]        s_axis_tuser,   // [0] op
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [23:0]       m_axis_tdata,   // [11:0] dac, [18:12] led, [20:19] stage
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [RATE_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending
);

	localparam longint TOP_LEVEL        = longint'(DAC_FULL) << LEVEL_FRACTION_BITS;
	localparam longint HALF_LEVEL       = TOP_LEVEL >>> 1;
	localparam int     PHASE_TERM_SHIFT = LEVEL_FRACTION_BITS + 10;
	localparam int     SKEW_SCALE_SHIFT = 11;   // rate * shape / 2048

	// same bit order as m_axis_tdata[20:0]
	typedef struct packed {
		logic [CODE_W-1:0] stage;
		logic [LED_W-1:0]  led;
		logic [DAC_W-1:0]  dac;
	} env_out_t;

	logic [1:0]        mode_q;
	longint            rise_rate;
	longint            fall_rate;
	longint            shape_q;
	longint            level_q;
	longint            phase_q;
	logic [CODE_W-1:0] stage_q;
	env_out_t          expected_q[$];
	int                n_fail = 0;
	int                n_pending = 0;

	assign fail_count = n_fail;
	assign pending    = n_pending;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		n_fail++;
	endtask

	function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// pull the phase toward where the curve must be to land on time
	function automatic longint bend_phase(input longint ph, input longint lvl);
		longint d;
		longint c;
		d = ph + HALF_LEVEL - lvl;
		c = (5 * d) / 2;   // truncates toward zero
		return clamp_span((shape_q > 0) ? ph + c : ph - c, -HALF_LEVEL, HALF_LEVEL);
	endfunction

	function automatic env_out_t advance_envelope(input logic is_trigger, input logic gate_low);
		longint     rise_skew;
		longint     fall_skew;
		longint     step;
		logic [63:0] lvl_bits;
		env_out_t   r;
		rise_skew = (rise_rate * shape_q) >>> SKEW_SCALE_SHIFT;
		fall_skew = (fall_rate * shape_q) >>> SKEW_SCALE_SHIFT;
		if (is_trigger) begin
			if (stage_q == CODE_RELEASE)
				phase_q = bend_phase(phase_q, level_q);
			stage_q = CODE_ATTACK;
		end else begin
			case (stage_q)
				CODE_ATTACK: begin
					step = rise_rate + ((phase_q * rise_skew) >>> PHASE_TERM_SHIFT);
					if (step > 0)
						level_q += step;
					phase_q += rise_rate;
					if (phase_q >= HALF_LEVEL) begin
						phase_q = HALF_LEVEL;
						stage_q = CODE_SUSTAIN;
					end else if (mode_q == MODE_GATE && gate_low) begin
						phase_q = bend_phase(phase_q, level_q);
						stage_q = CODE_RELEASE;
					end
				end
				CODE_SUSTAIN: begin
					if (mode_q != MODE_GATE || gate_low)
						stage_q = CODE_RELEASE;
				end
				CODE_RELEASE: begin
					step = fall_rate - ((phase_q * fall_skew) >>> PHASE_TERM_SHIFT);
					if (step > 0)
						level_q -= step;
					phase_q -= fall_rate;
					if (phase_q <= -HALF_LEVEL) begin
						phase_q = -HALF_LEVEL;
						level_q = 0;
						stage_q = CODE_END;
					end
				end
				default: begin
					if (mode_q == MODE_CYCLE)
						stage_q = CODE_ATTACK;
				end
			endcase
			level_q = clamp_span(level_q, 0, TOP_LEVEL);
		end
		lvl_bits = level_q;
		r.dac   = lvl_bits[LEVEL_FRACTION_BITS +: DAC_W];
		r.led   = lvl_bits[LEVEL_FRACTION_BITS + 5 +: LED_W];
		r.stage = stage_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		env_out_t got;
		env_out_t want;
		if (!arst_n) begin
			mode_q    = MODE_GATE;
			rise_rate = 1;
			fall_rate = 1;
			shape_q   = 0;
			level_q   = 0;
			phase_q   = -HALF_LEVEL;
			stage_q   = CODE_END;
			expected_q.delete();
			n_pending <= 0;
		end else begin
			// compare first: a result never belongs to an item taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got = env_out_t'(m_axis_tdata[20:0]);
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result dac=%0d led=%0d stage=%0d, none pending",
						got.dac, got.led, got.stage));
				end else begin
					want = expected_q.pop_front();
					if (got.dac !== want.dac)
						report_mismatch($sformatf("dac_value got %0d, expected %0d",
							got.dac, want.dac));
					if (got.led !== want.led)
						report_mismatch($sformatf("led_value got %0d, expected %0d",
							got.led, want.led));
					if (got.stage !== want.stage)
						report_mismatch($sformatf("stage_now got %0d, expected %0d",
							got.stage, want.stage));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_RUN_MODE:     mode_q    = cfg_data[1:0];
					REG_ATTACK_RATE:  rise_rate = longint'(cfg_data);
					REG_RELEASE_RATE: fall_rate = longint'(cfg_data);
					REG_SHAPE_SKEW:   shape_q   = longint'($signed(cfg_data[SHAPE_W-1:0]));
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(advance_envelope(s_axis_tuser[0], s_axis_tdata[0]));
			n_pending <= expected_q.size();
		end
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the envelope generator. Prediction and comparison
// live in envelope_checker, which sits beside the block and only watches.
module tb_top;
	import saeg_pkg::*;

	// input transaction codes
	localparam logic       OP_TICK      = 1'b0;
	localparam logic       OP_TRIGGER   = 1'b1;
	localparam logic       GATE_HIGH    = 1'b0;
	localparam logic       GATE_LOW     = 1'b1;

	// run_mode values the package does not name
	localparam logic [1:0] MODE_TRIGGER = 2'd2;
	localparam logic [1:0] MODE_UNDEF   = 2'd3;   // block treats it as trigger mode

	localparam logic [RATE_W-1:0]  RATE_TOP       = 27'd86682282;   // largest useful rate
	localparam logic [RATE_W-1:0]  RATE_FIELD_MAX = '1;
	localparam logic [SHAPE_W-1:0] SKEW_TOP       = 13'd2048;
	localparam logic [SHAPE_W-1:0] SKEW_BOTTOM    = -13'sd2047;
	localparam logic [SHAPE_W-1:0] SKEW_FIELD_MAX = 13'h0fff;
	localparam logic [SHAPE_W-1:0] SKEW_FIELD_MIN = 13'h1000;

	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int SETTLE_CYCLES = 4;   // margin behind the input and result registers

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // [0] gate_low, rest zero
	logic [0:0]        s_axis_tuser = '0;   // [0] op (0 tick, 1 trigger)

	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;        // [11:0] dac, [18:12] led, [20:19] stage

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [RATE_W-1:0] cfg_data = '0;

	int                fail_count;
	int                pending;

	bit                steady = 1'b0;   // no idling on either side
	bit                noisy = 1'b0;    // random op and gate on every transaction
	int                rx_stall = 0;
	int                rx_gap;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	skewed_ar_envelope_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	envelope_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// weighted toward rates that sweep the phase range in a handful of ticks
	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 11))
			0:       return RATE_W'(1);
			1:       return RATE_TOP;
			2:       return RATE_FIELD_MAX;
			3:       return '0;
			4:       return RATE_W'($urandom());
			default: return RATE_W'($urandom_range(2_000_000, 45_000_000));
		endcase
	endfunction

	// Receiver back-pressure: stalls of random length, off during steady stretches.
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
		end else begin
			rx_gap = (steady || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
			m_axis_tready <= (rx_gap == 0);
			rx_stall <= (rx_gap > 0) ? rx_gap - 1 : 0;
		end
	end

	// One input transaction. tvalid stays up when the next one follows at once,
	// so it is only dropped here when a gap is inserted.
	task automatic send_item(input logic op, input logic gate_low);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'b0, gate_low};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until the checker has nothing outstanding. pending is
	// registered in the checker, so it is trusted only after the following edge.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back on an idle block.
	task automatic load_settings(input logic [1:0] mode, input logic [RATE_W-1:0] rise,
			input logic [RATE_W-1:0] fall, input logic [SHAPE_W-1:0] skew);
		reg_idx_t          order [4] = '{REG_RUN_MODE, REG_ATTACK_RATE, REG_RELEASE_RATE,
			REG_SHAPE_SKEW};
		logic [RATE_W-1:0] value [4];
		value = '{RATE_W'(mode), rise, fall, RATE_W'(skew)};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= value[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		// skew scale factors are registered behind the written registers; let them settle
		repeat (2) @(posedge clk);
	endtask

	// Short scripted sequences: t/T tick with gate high/low, g/G trigger.
	task automatic play(input string script);
		for (int i = 0; i < script.len(); i++) begin
			case (script[i])
				"t": send_item(OP_TICK, GATE_HIGH);
				"T": send_item(OP_TICK, GATE_LOW);
				"g": send_item(OP_TRIGGER, GATE_HIGH);
				default: send_item(OP_TRIGGER, GATE_LOW);
			endcase
		end
	endtask

	initial begin
		logic [1:0]         mode;
		logic [SHAPE_W-1:0] skew;
		logic               gate_low;
		logic               op;
		int                 sent;
		int                 n;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: tick at end stage, trigger, gate falls in attack
		// (zero-skew compensation), then a trigger out of release.
		play("tgTg");

		// Fastest rates, full positive skew in gate mode: climb to sustain, hold,
		// release on gate low, retrigger during release, then gate low in attack.
		load_settings(MODE_GATE, RATE_TOP, RATE_TOP, SKEW_TOP);
		play("tttttTTGTTT");

		// Cycle mode restarts by itself; zero release rate holds the phase,
		// negative skew flips the compensation direction.
		load_settings(MODE_CYCLE, RATE_FIELD_MAX, '0, SKEW_BOTTOM);
		play("tttttg");

		// Undefined mode with a stalled attack and the most negative skew code.
		load_settings(MODE_UNDEF, '0, 27'd1, SKEW_FIELD_MIN);
		play("tTGt");

		// Random phases: fresh settings, then mostly well-formed envelopes with
		// long gate runs and sparse triggers; some phases are pure noise.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 6))
				0, 1:    mode = MODE_CYCLE;
				2, 3:    mode = MODE_GATE;
				4, 5:    mode = MODE_TRIGGER;
				default: mode = MODE_UNDEF;
			endcase
			case ($urandom_range(0, 9))
				0:       skew = SKEW_TOP;
				1:       skew = SKEW_BOTTOM;
				2:       skew = '0;
				3:       skew = SKEW_FIELD_MIN;
				4:       skew = SKEW_FIELD_MAX;
				5:       skew = SHAPE_W'($urandom());
				default: skew = SHAPE_W'($urandom_range(0, 4095) - 2047);
			endcase
			load_settings(mode, pick_rate(), pick_rate(), skew);
			steady = ($urandom_range(0, 3) == 0);
			noisy  = ($urandom_range(0, 4) == 0);
			n = $urandom_range(80, 220);
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			gate_low = 1'($urandom_range(0, 1));
			for (int i = 0; i < n; i++) begin
				if (noisy) begin
					gate_low = 1'($urandom_range(0, 1));
					op = $urandom_range(0, 1) ? OP_TRIGGER : OP_TICK;
				end else begin
					if ($urandom_range(0, 9) == 0)
						gate_low = ~gate_low;
					op = ($urandom_range(0, 7) == 0) ? OP_TRIGGER : OP_TICK;
				end
				send_item(op, gate_low);
				// occasional full drain in the middle of a phase
				if ($urandom_range(0, 299) == 0)
					wait_drained();
			end
			sent += n;
		end

		steady = 1'b0;
		wait_drained();
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hang guard: stops the run at a time far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
